// ===== rtl/core/prru_pkg.sv =====
// shared widths, limits and the factorial table for the permutation rank/unrank unit
`default_nettype none
package prru_pkg;

    localparam int MAX_N      = 20;
    localparam int ELEM_W     = 5;
    localparam int RANK_W     = 62;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    localparam logic [0:0] MODE_UNRANK = 1'b0;
    localparam logic [0:0] MODE_RANK   = 1'b1;

    localparam logic [0:0] REG_LENGTH = 1'b0;
    localparam logic [0:0] REG_MODE   = 1'b1;

    typedef logic [RANK_W-1:0] t_rank;
    typedef logic [ELEM_W-1:0] t_elem;

    // factorial weights 0! .. 20!
    function automatic t_rank fact(input t_elem idx);
        t_rank f;
        case (idx)
            5'd0:    f = 62'd1;
            5'd1:    f = 62'd1;
            5'd2:    f = 62'd2;
            5'd3:    f = 62'd6;
            5'd4:    f = 62'd24;
            5'd5:    f = 62'd120;
            5'd6:    f = 62'd720;
            5'd7:    f = 62'd5040;
            5'd8:    f = 62'd40320;
            5'd9:    f = 62'd362880;
            5'd10:   f = 62'd3628800;
            5'd11:   f = 62'd39916800;
            5'd12:   f = 62'd479001600;
            5'd13:   f = 62'd6227020800;
            5'd14:   f = 62'd87178291200;
            5'd15:   f = 62'd1307674368000;
            5'd16:   f = 62'd20922789888000;
            5'd17:   f = 62'd355687428096000;
            5'd18:   f = 62'd6402373705728000;
            5'd19:   f = 62'd121645100408832000;
            5'd20:   f = 62'd2432902008176640000;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/permutation_rank_unrank_unit.sv =====
// permutation rank/unrank unit: factorial number system with one shared add/subtract unit
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata: target_rank, element
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: element_out, rank_out;
//                                                     tlast: last; tuser: error
//  cfg       in         i_cfg_we                      i_cfg_index, i_cfg_data
//
//  unrank: accept state, check state, then one candidate per cycle up to the chosen
//  element for each position, held while a stalled output blocks its result
//  rank: accept state, check state, a scan up to element e and, after the last element,
//  a final rank state; a bad element ends the run in the check state
//  synchronous active-low reset clears the sequencer, the run state and the output valid
//  a stalled output only holds the sequencer when it needs to load a new result
`default_nettype none
module permutation_rank_unrank_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [61:0] target_rank, [66:62] element, [71:67] zero
    input  wire logic [prru_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [4:0] element_out, [66:5] rank_out, [71:67] zero
    output logic [prru_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    // [0] error
    output logic                                m_axis_tuser,
    input  wire logic                           i_cfg_we,
    input  wire logic [0:0]                     i_cfg_index,
    input  wire logic [prru_pkg::ELEM_W-1:0]    i_cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_U_CHK  = 3'd1;
    localparam logic [2:0] ST_U_SCAN = 3'd2;
    localparam logic [2:0] ST_R_CHK  = 3'd3;
    localparam logic [2:0] ST_R_SCAN = 3'd4;
    localparam logic [2:0] ST_R_DONE = 3'd5;

    logic [2:0]              r_state, n_state;
    prru_pkg::t_elem         r_len, n_len;
    logic [0:0]              r_mode, n_mode;
    logic [prru_pkg::MAX_N-1:0] r_used, n_used;
    prru_pkg::t_elem         r_rem, n_rem;
    prru_pkg::t_rank         r_acc, n_acc;
    prru_pkg::t_rank         r_k, n_k;
    prru_pkg::t_rank         r_f, n_f;
    prru_pkg::t_elem         r_i, n_i;
    prru_pkg::t_elem         r_pos, n_pos;
    prru_pkg::t_elem         r_e, n_e;

    logic                    r_ov, n_ov;
    prru_pkg::t_elem         r_oel, n_oel;
    prru_pkg::t_rank         r_ork, n_ork;
    logic                    r_olast, n_olast;
    logic                    r_oerr, n_oerr;

    prru_pkg::t_elem         w_n;
    logic                    w_out_free;
    logic                    w_accept;
    logic                    w_alu_sub;
    prru_pkg::t_rank         w_alu_a, w_alu_b, w_alu_y;

    // length saturated to 1..MAX_N
    always_comb begin
        if (r_len == '0) begin
            w_n = prru_pkg::t_elem'(1);
        end else if (r_len > prru_pkg::t_elem'(prru_pkg::MAX_N)) begin
            w_n = prru_pkg::t_elem'(prru_pkg::MAX_N);
        end else begin
            w_n = r_len;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ov || m_axis_tready;

    // shared unit: k - f while unranking, acc + f or acc + 1 while ranking
    always_comb begin
        w_alu_sub = (r_state == ST_U_SCAN);
        w_alu_a   = w_alu_sub ? r_k : r_acc;
        w_alu_b   = (r_state == ST_R_DONE) ? prru_pkg::t_rank'(1) : r_f;
        w_alu_y   = w_alu_sub ? (w_alu_a - w_alu_b) : (w_alu_a + w_alu_b);
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_mode  = r_mode;
        n_used  = r_used;
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_k     = r_k;
        n_f     = r_f;
        n_i     = r_i;
        n_pos   = r_pos;
        n_e     = r_e;
        n_ov    = r_ov && !m_axis_tready;
        n_oel   = r_oel;
        n_ork   = r_ork;
        n_olast = r_olast;
        n_oerr  = r_oerr;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_mode == prru_pkg::MODE_UNRANK) begin
                        n_k     = s_axis_tdata[61:0];
                        n_used  = '0;
                        n_rem   = '0;
                        n_acc   = '0;
                        n_state = ST_U_CHK;
                    end else begin
                        n_e = s_axis_tdata[66:62];
                        // a fresh rank run clears its state
                        if (r_rem == '0 || r_rem > w_n) begin
                            n_used = '0;
                            n_acc  = '0;
                            n_rem  = w_n;
                        end
                        n_state = ST_R_CHK;
                    end
                end
            end
            ST_U_CHK: begin
                if (r_k == '0 || r_k > prru_pkg::fact(w_n)) begin
                    if (w_out_free) begin
                        n_ov    = 1'b1;
                        n_oel   = '0;
                        n_ork   = '0;
                        n_olast = 1'b1;
                        n_oerr  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_pos   = w_n;
                    n_f     = prru_pkg::fact(w_n - 5'd1);
                    n_i     = 5'd1;
                    n_state = ST_U_SCAN;
                end
            end
            ST_U_SCAN: begin
                if (r_used[r_i - 5'd1]) begin
                    n_i = r_i + 5'd1;
                end else if (r_k <= r_f) begin
                    if (w_out_free) begin
                        n_ov               = 1'b1;
                        n_oel              = r_i;
                        n_ork              = '0;
                        n_olast            = (r_pos == 5'd1);
                        n_oerr             = 1'b0;
                        n_used[r_i - 5'd1] = 1'b1;
                        n_i                = 5'd1;
                        if (r_pos == 5'd1) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_pos = r_pos - 5'd1;
                            n_f   = prru_pkg::fact(r_pos - 5'd2);
                        end
                    end
                end else begin
                    n_k = w_alu_y;
                    n_i = r_i + 5'd1;
                end
            end
            ST_R_CHK: begin
                if (r_e == '0 || r_e > w_n || r_used[r_e - 5'd1]) begin
                    if (w_out_free) begin
                        n_ov    = 1'b1;
                        n_oel   = '0;
                        n_ork   = '0;
                        n_olast = 1'b1;
                        n_oerr  = 1'b1;
                        n_rem   = '0;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_rem   = r_rem - 5'd1;
                    n_f     = prru_pkg::fact(r_rem - 5'd1);
                    n_i     = 5'd1;
                    n_state = ST_R_SCAN;
                end
            end
            ST_R_SCAN: begin
                if (r_i == r_e) begin
                    n_used[r_e - 5'd1] = 1'b1;
                    n_state = (r_rem == '0) ? ST_R_DONE : ST_IDLE;
                end else begin
                    // each smaller unused element adds one weight
                    if (!r_used[r_i - 5'd1]) begin
                        n_acc = w_alu_y;
                    end
                    n_i = r_i + 5'd1;
                end
            end
            ST_R_DONE: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_oel   = '0;
                    n_ork   = w_alu_y;
                    n_olast = 1'b1;
                    n_oerr  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_rem = '0;
            case (i_cfg_index)
                prru_pkg::REG_LENGTH: n_len  = i_cfg_data;
                prru_pkg::REG_MODE:   n_mode = i_cfg_data[0:0];
                default:              n_len  = r_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= 5'd1;
            r_mode  <= prru_pkg::MODE_UNRANK;
            r_used  <= '0;
            r_rem   <= '0;
            r_acc   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_mode  <= n_mode;
            r_used  <= n_used;
            r_rem   <= n_rem;
            r_acc   <= n_acc;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_f     <= n_f;
        r_i     <= n_i;
        r_pos   <= n_pos;
        r_e     <= n_e;
        r_oel   <= n_oel;
        r_ork   <= n_ork;
        r_olast <= n_olast;
        r_oerr  <= n_oerr;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'd0, r_ork, r_oel};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oerr;

    // candidate index stays within 1..N during the unrank scan
    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_U_SCAN) |-> (r_i != '0 && r_i <= w_n))
        else $error("unrank scan index out of range");

    // remaining rank value never drops to zero mid-scan
    a_k_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_U_SCAN) |-> (r_k != '0))
        else $error("unrank residual rank reached zero");

    // an error result always closes the run
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("error result without last");

    // remaining run count never exceeds N
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=> (r_rem <= w_n))
        else $error("remaining count beyond length");

    // a good rank result is one-based
    a_rank_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser && m_axis_tlast && r_oel == '0)
        |-> (r_ork != '0))
        else $error("rank result is zero");

endmodule
`default_nettype wire

// ===== tb/perm_rank_checker.sv =====
// checker for the permutation rank/unrank unit: predicts every output transfer and compares
`default_nettype none
module perm_rank_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    // [61:0] target_rank, [66:62] element, [71:67] zero
    input  wire logic [prru_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [4:0] element_out, [66:5] rank_out, [71:67] zero
    input  wire logic [prru_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                           m_axis_tlast,
    // [0] error
    input  wire logic                           m_axis_tuser,
    input  wire logic                           i_cfg_we,
    input  wire logic [0:0]                     i_cfg_index,
    input  wire logic [prru_pkg::ELEM_W-1:0]    i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        prru_pkg::t_elem elem;
        prru_pkg::t_rank rank;
        logic            last;
        logic            err;
    } t_perm_result;

    t_perm_result expected_results[$];

    // shadow of the block's registers and run state
    logic [4:0]                 cfg_length;
    logic [0:0]                 cfg_mode;
    logic [prru_pkg::MAX_N-1:0] used_mask;
    logic [4:0]                 left_count;
    prru_pkg::t_rank            partial_rank;

    t_perm_result                    head;
    logic [prru_pkg::OUT_DATA_W-1:0] want_data;

    function automatic prru_pkg::t_rank factorial(input int unsigned n);
        prru_pkg::t_rank f = 1;
        for (int i = 2; i <= n; i++) begin
            f = f * prru_pkg::t_rank'(i);
        end
        return f;
    endfunction

    function automatic int unsigned run_length();
        int unsigned n = cfg_length;
        if (n < 1) begin
            n = 1;
        end
        if (n > prru_pkg::MAX_N) begin
            n = prru_pkg::MAX_N;
        end
        return n;
    endfunction

    task automatic push_result(input prru_pkg::t_elem elem, input prru_pkg::t_rank rank,
                               input logic last, input logic err);
        t_perm_result r;
        r.elem = elem;
        r.rank = rank;
        r.last = last;
        r.err  = err;
        expected_results.push_back(r);
    endtask

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // rank -> elements, picking the k-th unused element against each factorial weight
    task automatic predict_unrank(input prru_pkg::t_rank target);
        int unsigned n;
        prru_pkg::t_rank k;
        prru_pkg::t_rank f;
        prru_pkg::t_rank acc;
        n = run_length();
        k = target;
        left_count = '0;
        partial_rank = '0;
        used_mask = '0;
        if (k == 0 || k > factorial(n)) begin
            push_result('0, '0, 1'b1, 1'b1);
            return;
        end
        for (int r = n; r > 0; r--) begin
            f = factorial(r - 1);
            acc = '0;
            for (int i = 1; i <= n; i++) begin
                if (!used_mask[i-1]) begin
                    acc = acc + f;
                    if (acc >= k) begin
                        used_mask[i-1] = 1'b1;
                        k = k - (acc - f);
                        push_result(prru_pkg::t_elem'(i), '0, r == 1, 1'b0);
                        break;
                    end
                end
            end
        end
    endtask

    // one element of a rank run; a result only on the last element or an error
    task automatic predict_rank(input prru_pkg::t_elem e);
        int unsigned n;
        int unsigned below;
        n = run_length();
        below = 0;
        if (left_count == 0 || left_count > n) begin
            used_mask = '0;
            partial_rank = '0;
            left_count = 5'(n);
        end
        if (e < 1 || e > n) begin
            left_count = '0;
            push_result('0, '0, 1'b1, 1'b1);
            return;
        end
        if (used_mask[e-1]) begin
            left_count = '0;
            push_result('0, '0, 1'b1, 1'b1);
            return;
        end
        for (int i = 1; i < e; i++) begin
            if (!used_mask[i-1]) begin
                below++;
            end
        end
        left_count = left_count - 1'b1;
        partial_rank = partial_rank + prru_pkg::t_rank'(below) * factorial(left_count);
        used_mask[e-1] = 1'b1;
        if (left_count == 0) begin
            push_result('0, partial_rank + 1'b1, 1'b1, 1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_length   = 5'd1;
            cfg_mode     = prru_pkg::MODE_UNRANK;
            used_mask    = '0;
            left_count   = '0;
            partial_rank = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == prru_pkg::REG_LENGTH) begin
                    cfg_length = i_cfg_data;
                end else begin
                    cfg_mode = i_cfg_data[0];
                end
                left_count = '0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result: element %0d rank %0d last %b error %b",
                        m_axis_tdata[4:0], m_axis_tdata[66:5], m_axis_tlast, m_axis_tuser));
                end else begin
                    head = expected_results.pop_front();
                    want_data = {5'd0, head.rank, head.elem};
                    if (m_axis_tdata !== want_data || m_axis_tlast !== head.last ||
                        m_axis_tuser !== head.err) begin
                        note_failure($sformatf({"result mismatch: expected element %0d ",
                            "rank %0d last %b error %b, got element %0d rank %0d ",
                            "last %b error %b pad %h"},
                            head.elem, head.rank, head.last, head.err,
                            m_axis_tdata[4:0], m_axis_tdata[66:5], m_axis_tlast,
                            m_axis_tuser, m_axis_tdata[71:67]));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (cfg_mode == prru_pkg::MODE_UNRANK) begin
                    predict_unrank(s_axis_tdata[61:0]);
                end else begin
                    predict_rank(s_axis_tdata[66:62]);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule
`default_nettype wire

// ===== tb/tb_permutation_rank_unrank_unit.sv =====
// testbench top for the permutation rank/unrank unit: stimulus, flow control and verdict
`default_nettype none
module tb_permutation_rank_unrank_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT      = 32;
    // settle wait that lets a rank element with no result finish its check and scan
    localparam int SETTLE_CYCLES = 450;
    localparam int HOLD_CYCLES   = 500;
    // worst quiet gap: a settle wait or a receiver hold, taken several times
    localparam int STALL_LIMIT   = 5000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [prru_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [prru_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            m_axis_tuser;
    logic                            i_cfg_we;
    logic [0:0]                      i_cfg_index;
    logic [prru_pkg::ELEM_W-1:0]     i_cfg_data;

    int fail_count;
    int pending;
    int stall_count;
    int hold_left;
    bit calm;
    bit hold_go;
    bit hold_seen;

    permutation_rank_unrank_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    perm_rank_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("tb_permutation_rank_unrank_unit failed");
            $finish;
        end
    end

    function automatic int unsigned sat_length(input int len);
        if (len < 1) begin
            return 1;
        end
        if (len > prru_pkg::MAX_N) begin
            return prru_pkg::MAX_N;
        end
        return len;
    endfunction

    function automatic logic [prru_pkg::IN_DATA_W-1:0] rank_item(input prru_pkg::t_rank k);
        return {5'd0, prru_pkg::t_elem'($urandom), k};
    endfunction

    function automatic logic [prru_pkg::IN_DATA_W-1:0] elem_item(input prru_pkg::t_elem e);
        return {5'd0, e, prru_pkg::t_rank'({$urandom, $urandom})};
    endfunction

    // mostly legal ranks, with the bounds and out-of-range values mixed in
    function automatic prru_pkg::t_rank pick_rank(input int unsigned n);
        prru_pkg::t_rank f;
        int unsigned roll;
        f = prru_pkg::fact(prru_pkg::t_elem'(n));
        roll = $urandom_range(99);
        if (roll < 5) begin
            return '0;
        end else if (roll < 10) begin
            return f + 1'b1;
        end else if (roll < 15) begin
            return prru_pkg::t_rank'({$urandom, $urandom});
        end else if (roll < 22) begin
            return f;
        end else if (roll < 27) begin
            return prru_pkg::t_rank'(1);
        end
        return (prru_pkg::t_rank'({$urandom, $urandom}) % f) + 1'b1;
    endfunction

    // called right after a falling edge; returns right after the falling edge after the transfer
    task automatic send_item(input logic [prru_pkg::IN_DATA_W-1:0] d);
        if (!calm && $urandom_range(99) < 2) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
            while (pending != 0) begin
                @(negedge i_clk);
            end
        end
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [prru_pkg::ELEM_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // drain all results, then give a run with no result time to finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input int len, input logic [0:0] m);
        settle();
        write_reg(prru_pkg::REG_LENGTH, prru_pkg::t_elem'(len));
        write_reg(prru_pkg::REG_MODE, {4'd0, m});
    endtask

    // one shuffled permutation, now and then broken by a bad element
    task automatic send_permutation(input int unsigned n, output bit good);
        prru_pkg::t_elem perm[prru_pkg::MAX_N];
        prru_pkg::t_elem tmp;
        int unsigned j;
        int unsigned p;
        for (int i = 0; i < n; i++) begin
            perm[i] = prru_pkg::t_elem'(i + 1);
        end
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        good = 1'b1;
        if ($urandom_range(99) < 15) begin
            good = 1'b0;
            p = $urandom_range(n - 1);
            case ($urandom_range(2))
                0: begin
                    perm[p] = '0;
                end
                1: begin
                    perm[p] = prru_pkg::t_elem'($urandom_range(31, n + 1));
                end
                default: begin
                    perm[p] = (p > 0) ? perm[p-1] : '0;
                end
            endcase
        end
        for (int i = 0; i < n; i++) begin
            send_item(elem_item(perm[i]));
        end
    endtask

    initial begin : stimulus
        int sent;
        int runs;
        int phase;
        int len;
        int unsigned n;
        int items;
        logic [0:0] m;
        bit good;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        calm          = 1'b0;
        hold_go       = 1'b0;
        sent          = 0;
        runs          = 0;
        phase         = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values: length 1, unrank
        send_item(rank_item(prru_pkg::t_rank'(1)));
        send_item(rank_item('0));
        send_item(rank_item(prru_pkg::t_rank'(2)));

        configure(20, prru_pkg::MODE_UNRANK);
        send_item(rank_item(prru_pkg::t_rank'(1)));
        send_item(rank_item(prru_pkg::fact(prru_pkg::t_elem'(20))));
        send_item(rank_item(prru_pkg::fact(prru_pkg::t_elem'(20)) + 1'b1));
        send_item(rank_item('1));

        configure(4, prru_pkg::MODE_RANK);
        send_item(elem_item(prru_pkg::t_elem'(2)));
        send_item(elem_item(prru_pkg::t_elem'(4)));
        send_item(elem_item(prru_pkg::t_elem'(1)));
        send_item(elem_item(prru_pkg::t_elem'(3)));
        send_item(elem_item('0));
        send_item(elem_item(prru_pkg::t_elem'(5)));
        send_item(elem_item(prru_pkg::t_elem'(1)));
        send_item(elem_item(prru_pkg::t_elem'(1)));
        // partial run, dropped by the next register write
        send_item(elem_item(prru_pkg::t_elem'(3)));
        send_item(elem_item(prru_pkg::t_elem'(1)));

        configure(0, prru_pkg::MODE_RANK);
        send_item(elem_item(prru_pkg::t_elem'(1)));
        send_item(elem_item('1));

        configure(31, prru_pkg::MODE_UNRANK);
        send_item(rank_item(prru_pkg::fact(prru_pkg::t_elem'(20))));
        send_item(rank_item(prru_pkg::t_rank'(1)));

        while (sent < 300 || runs < 30 || phase < 6) begin
            case ($urandom_range(19))
                0:       len = 0;
                1:       len = $urandom_range(31, 21);
                2, 3:    len = $urandom_range(20, 13);
                default: len = $urandom_range(8, 1);
            endcase
            m = 1'($urandom_range(1));
            // the calm stretch is a full unrank phase
            if (phase == 3) begin
                len = 8;
                m = prru_pkg::MODE_UNRANK;
            end
            if (phase == 5) begin
                len = 6;
                m = prru_pkg::MODE_UNRANK;
            end
            n = sat_length(len);
            configure(len, m);
            calm = (phase == 3);
            if (phase == 5) begin
                hold_go = 1'b1;
            end
            if (m == prru_pkg::MODE_UNRANK) begin
                items = (n > 12) ? $urandom_range(10, 4) : $urandom_range(24, 8);
                for (int i = 0; i < items; i++) begin
                    send_item(rank_item(pick_rank(n)));
                    sent++;
                end
            end else begin
                items = $urandom_range(8, 3);
                for (int i = 0; i < items; i++) begin
                    if ($urandom_range(99) < 10) begin
                        send_item(elem_item(prru_pkg::t_elem'($urandom)));
                        sent++;
                    end
                    send_permutation(n, good);
                    sent += n;
                    if (good) begin
                        runs++;
                    end
                end
            end
            phase++;
        end
        calm = 1'b0;

        settle();
        if (fail_count == 0) begin
            $display("tb_permutation_rank_unrank_unit passed");
        end else begin
            $display("tb_permutation_rank_unrank_unit failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
